// ===== hdl/iq_dc_offset_estimate_remove_macros.svh =====
// ----------------------------------------------------------------------------
// IQ DC offset remover assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IQ_DC_OFFSET_ESTIMATE_REMOVE_MACROS_SVH
`define IQ_DC_OFFSET_ESTIMATE_REMOVE_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define IQDC_ASSERT_HOLD(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define IQDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/iqdc_pkg.sv =====
// ----------------------------------------------------------------------------
// IQ DC offset remover package
// Sizes, request types, back end states and the sample wrap helper.
// ----------------------------------------------------------------------------
`default_nettype none

package iqdc_pkg;

	localparam int LANES      = 8;
	localparam int LANE_W     = $clog2(LANES);
	localparam int SAMPLE_W   = 16;
	localparam int GROUP_W    = LANES * SAMPLE_W;
	localparam int MAX_GROUPS = 64;
	localparam int ADDR_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int FILL_W     = $clog2(MAX_GROUPS + 1);
	localparam int SUM_W      = SAMPLE_W + FILL_W;
	localparam int WEIGHT_W   = 17;
	localparam int FRAC_W     = 16;
	localparam int P2_W       = SAMPLE_W + WEIGHT_W + 1;
	localparam int NUM_W      = SUM_W + WEIGHT_W + 1;
	localparam int QUO_W      = NUM_W - FRAC_W;
	localparam int STEP_W     = $clog2(QUO_W);
	localparam int CMD_DEPTH  = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(65536);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(6554);

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = CFG_IDX_W'(2);

	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// one finished packet handed from the front to the back
	typedef struct packed {
		logic [FILL_W-1:0]   count;
		logic                recal;
		logic [WEIGHT_W-1:0] weight;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL1,
		B_MUL2,
		B_ADD,
		B_SCALE,
		B_DIV,
		B_FIX,
		B_EMIT
	} back_state_t;

	// fmt 1: 16-bit sample; fmt 0: low byte sign-extended
	function automatic sample_t wrap_sample(input logic [SAMPLE_W-1:0] v, input logic fmt);
		sample_t r;
		r = fmt ? sample_t'(v) : sample_t'({{(SAMPLE_W-8){v[7]}}, v[7:0]});
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/iq_dc_offset_estimate_remove.sv =====
// ----------------------------------------------------------------------------
// IQ DC offset estimate and remove
// Buffers a packet of I/Q groups, updates per-lane offsets, emits it corrected.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// in        input      in_valid/in_stall    lane_zero..lane_seven, packet_end,
//                                           first_packet, packet_count
// out       output     out_valid/out_stall  out_zero..out_seven, out_last
// cfg       input      cfg_write            cfg_index, cfg_data
//
// Loading accepts one group per cycle while in_stall is low; the input stalls
// from packet end until the last group of that packet has been read from the
// buffer RAM, and while the request queue is full. A recalibration uses one
// shared set of multipliers and a one-bit-per-cycle divider, lane by lane.
// Emission issues each group read from the registered RAM once the last is captured.
// Reset clears offsets, sums and fill; the buffer RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module iq_dc_offset_estimate_remove import iqdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WEIGHT_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          lane_zero,
	input  logic [15:0]          lane_one,
	input  logic [15:0]          lane_two,
	input  logic [15:0]          lane_three,
	input  logic [15:0]          lane_four,
	input  logic [15:0]          lane_five,
	input  logic [15:0]          lane_six,
	input  logic [15:0]          lane_seven,
	input  logic                 packet_end,
	input  logic                 first_packet,
	input  logic [3:0]           packet_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          out_zero,
	output logic [15:0]          out_one,
	output logic [15:0]          out_two,
	output logic [15:0]          out_three,
	output logic [15:0]          out_four,
	output logic [15:0]          out_five,
	output logic [15:0]          out_six,
	output logic [15:0]          out_seven,
	output logic                 out_last
);

	logic                enable_q;
	logic                fmt_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic [GROUP_W-1:0]  group;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [GROUP_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [GROUP_W-1:0]  ram_rdata;
	logic                push;
	cmd_t                push_cmd;
	logic                q_full;
	logic                q_empty;
	logic                pop;
	cmd_t                cmd;
	logic                release_buf;
	sum_t                sums [LANES];
	logic [GROUP_W-1:0]  out_group;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			fmt_q    <= 1'b1;
			weight_q <= WEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_FORMAT: fmt_q    <= cfg_data[0];
				REG_WEIGHT: weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign group = {lane_seven, lane_six, lane_five, lane_four,
		lane_three, lane_two, lane_one, lane_zero};

	iqdc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.fmt          (fmt_q),
		.enable       (enable_q),
		.weight       (weight_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.group        (group),
		.packet_end   (packet_end),
		.first_packet (first_packet),
		.packet_count (packet_count),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.push         (push),
		.push_cmd     (push_cmd),
		.q_full       (q_full),
		.release_buf  (release_buf),
		.sums         (sums)
	);

	iqdc_ram #(
		.WIDTH (GROUP_W),
		.DEPTH (MAX_GROUPS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iqdc_cmd_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	iqdc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fmt         (fmt_q),
		.enable      (enable_q),
		.cmd_empty   (q_empty),
		.cmd         (cmd),
		.pop         (pop),
		.sums        (sums),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.release_buf (release_buf),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_group   (out_group),
		.out_last    (out_last)
	);

	assign out_zero  = out_group[0*16 +: 16];
	assign out_one   = out_group[1*16 +: 16];
	assign out_two   = out_group[2*16 +: 16];
	assign out_three = out_group[3*16 +: 16];
	assign out_four  = out_group[4*16 +: 16];
	assign out_five  = out_group[5*16 +: 16];
	assign out_six   = out_group[6*16 +: 16];
	assign out_seven = out_group[7*16 +: 16];

endmodule

`default_nettype wire

// ===== hdl/iqdc_ram.sv =====
// ----------------------------------------------------------------------------
// IQ DC offset remover generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iqdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/iqdc_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// IQ DC offset remover request queue
// Short queue of packet requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module iqdc_cmd_fifo import iqdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(CMD_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push && !full) - CNT_W'(pop && !empty);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/iqdc_front.sv =====
// ----------------------------------------------------------------------------
// IQ DC offset remover front end
// Accepts groups, buffers them, sums each lane and issues a packet request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iq_dc_offset_estimate_remove_macros.svh"

module iqdc_front import iqdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fmt,
	input  logic                enable,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [GROUP_W-1:0]  group,
	input  logic                packet_end,
	input  logic                first_packet,
	input  logic [3:0]          packet_count,
	output logic                ram_we,
	output logic [ADDR_W-1:0]   ram_waddr,
	output logic [GROUP_W-1:0]  ram_wdata,
	output logic                push,
	output cmd_t                push_cmd,
	input  logic                q_full,
	input  logic                release_buf,
	output sum_t                sums [LANES]
);

	logic              busy_q;
	logic [FILL_W-1:0] fill_q;
	sum_t              sums_q [LANES];
	logic              accept;
	logic              room;

	assign in_stall  = busy_q || q_full;
	assign accept    = in_valid && !in_stall;
	assign room      = (fill_q < FILL_W'(MAX_GROUPS));
	assign ram_we    = accept && room;
	assign ram_waddr = fill_q[ADDR_W-1:0];
	assign ram_wdata = group;
	assign push      = accept && packet_end;
	assign sums      = sums_q;

	always_comb begin
		push_cmd.count  = fill_q + FILL_W'(ram_we);
		push_cmd.recal  = enable && (first_packet || (packet_count == 4'd0));
		push_cmd.weight = first_packet ? WEIGHT_ONE :
			((weight > WEIGHT_ONE) ? WEIGHT_ONE : weight);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fill_q <= '0;
			for (int j = 0; j < LANES; j++) sums_q[j] <= '0;
		end else if (release_buf) begin
			busy_q <= 1'b0;
			fill_q <= '0;
			for (int j = 0; j < LANES; j++) sums_q[j] <= '0;
		end else begin
			if (ram_we) begin
				fill_q <= fill_q + FILL_W'(1);
				for (int j = 0; j < LANES; j++) begin
					sums_q[j] <= sums_q[j] +
						SUM_W'(wrap_sample(group[j*SAMPLE_W +: SAMPLE_W], fmt));
				end
			end
			// hold the buffer until the back end has read it out
			if (push) begin
				busy_q <= 1'b1;
			end
		end
	end

	`IQDC_ASSERT_HOLD(a_fill_bound, 1'b1, fill_q <= FILL_W'(MAX_GROUPS), "fill beyond capacity")
	`IQDC_ASSERT_HOLD(a_no_write_busy, busy_q, !ram_we, "buffer written while owned by back end")

endmodule

`default_nettype wire

// ===== hdl/iqdc_back.sv =====
// ----------------------------------------------------------------------------
// IQ DC offset remover back end
// Recalibrates offsets lane by lane if requested, then streams the corrected packet.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iq_dc_offset_estimate_remove_macros.svh"

module iqdc_back import iqdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fmt,
	input  logic               enable,
	input  logic               cmd_empty,
	input  cmd_t               cmd,
	output logic               pop,
	input  sum_t               sums [LANES],
	output logic [ADDR_W-1:0]  ram_raddr,
	input  logic [GROUP_W-1:0] ram_rdata,
	output logic               release_buf,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [GROUP_W-1:0] out_group,
	output logic               out_last
);

	back_state_t          state_q;
	back_state_t          state_d;
	logic [FILL_W-1:0]    cnt_q;
	logic [WEIGHT_W-1:0]  w_q;
	logic [LANE_W-1:0]    lane_q;
	logic signed [NUM_W-1:0] p1_q;
	logic signed [P2_W-1:0]  p2_q;
	logic signed [NUM_W-1:0] p3_q;
	logic signed [NUM_W-1:0] num_q;
	logic                 neg_q;
	logic [QUO_W-1:0]     quo_q;
	logic [FILL_W-1:0]    rem_q;
	logic [STEP_W-1:0]    step_q;
	sample_t              offs_q [LANES];
	logic [FILL_W-1:0]    grp_q;
	logic                 all_q;
	logic                 pend_q;
	logic                 last_pend_q;
	logic                 ov_q;
	logic [GROUP_W-1:0]   out_q;
	logic                 olast_q;

	logic                 issue;
	logic                 done;
	logic [FILL_W:0]      trial;
	logic                 ge;
	logic [FILL_W-1:0]    rem_next;
	logic [NUM_W-1:0]     mag;
	logic [QUO_W-1:0]     qs;
	sample_t              off_cur;
	logic [GROUP_W-1:0]   corr;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (!cmd_empty) state_d = cmd.recal ? B_MUL1 : B_EMIT;
			B_MUL1:  state_d = B_MUL2;
			B_MUL2:  state_d = B_ADD;
			B_ADD:   state_d = B_SCALE;
			B_SCALE: state_d = B_DIV;
			B_DIV:   if (step_q == STEP_W'(QUO_W - 1)) state_d = B_FIX;
			B_FIX:   state_d = (lane_q == LANE_W'(LANES - 1)) ? B_EMIT : B_MUL1;
			B_EMIT:  if (done) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop   = (state_q == B_IDLE) && !cmd_empty;
		issue = (state_q == B_EMIT) && !all_q && !pend_q && (!ov_q || !out_stall);
		done  = (state_q == B_EMIT) && pend_q && last_pend_q;
	end

	assign release_buf = done;
	assign ram_raddr   = grp_q[ADDR_W-1:0];
	assign out_valid   = ov_q;
	assign out_group   = out_q;
	assign out_last    = olast_q;

	// restoring divide step: one quotient bit a cycle
	always_comb begin
		trial    = {rem_q, quo_q[QUO_W-1]};
		ge       = (trial >= {1'b0, cnt_q});
		rem_next = ge ? FILL_W'(trial - {1'b0, cnt_q}) : trial[FILL_W-1:0];
		mag      = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
		qs       = neg_q ? QUO_W'(-quo_q) : quo_q;
		off_cur  = wrap_sample(offs_q[lane_q], fmt);
	end

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			corr[j*SAMPLE_W +: SAMPLE_W] = wrap_sample(
				ram_rdata[j*SAMPLE_W +: SAMPLE_W] - (enable ? offs_q[j] : sample_t'(0)), fmt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			lane_q      <= '0;
			grp_q       <= '0;
			all_q       <= 1'b0;
			pend_q      <= 1'b0;
			last_pend_q <= 1'b0;
			ov_q        <= 1'b0;
			for (int j = 0; j < LANES; j++) offs_q[j] <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				lane_q <= '0;
				grp_q  <= '0;
				all_q  <= 1'b0;
			end
			if (state_q == B_FIX) begin
				offs_q[lane_q] <= wrap_sample(qs[SAMPLE_W-1:0], fmt);
				lane_q         <= lane_q + LANE_W'(1);
			end
			if (issue) begin
				grp_q       <= grp_q + FILL_W'(1);
				pend_q      <= 1'b1;
				last_pend_q <= (grp_q == cnt_q - FILL_W'(1));
				if (grp_q == cnt_q - FILL_W'(1)) all_q <= 1'b1;
			end else if (pend_q) begin
				pend_q <= 1'b0;
			end
			if (pend_q) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cnt_q <= cmd.count;
			w_q   <= cmd.weight;
		end
		case (state_q)
			B_MUL1: begin
				p1_q <= NUM_W'(sums[lane_q]) * NUM_W'($signed({1'b0, w_q}));
				p2_q <= P2_W'(off_cur) * P2_W'($signed({1'b0, WEIGHT_ONE - w_q}));
			end
			B_MUL2:  p3_q  <= NUM_W'(p2_q) * NUM_W'($signed({1'b0, cnt_q}));
			B_ADD:   num_q <= p1_q + p3_q;
			B_SCALE: begin
				// truncate toward zero: magnitude shift, sign restored after divide
				neg_q  <= num_q[NUM_W-1];
				quo_q  <= mag[NUM_W-1:FRAC_W];
				rem_q  <= '0;
				step_q <= '0;
			end
			B_DIV: begin
				quo_q  <= {quo_q[QUO_W-2:0], ge};
				rem_q  <= rem_next;
				step_q <= step_q + STEP_W'(1);
			end
			default: ;
		endcase
		if (pend_q) begin
			out_q   <= corr;
			olast_q <= last_pend_q;
		end
	end

	`IQDC_ASSERT_NEXT(a_load_shows, pend_q, ov_q, "read group not presented")
	`IQDC_ASSERT_HOLD(a_div_rem, state_q == B_DIV, rem_q < cnt_q, "divider remainder out of range")

endmodule

`default_nettype wire
